// ===== rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Shared constants, operation codes, command/status types and the digit
// encoding table.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int PTR_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int NUM_W       = 16;
  localparam int SEG_W       = 8;
  localparam int EN_W        = 4;
  localparam int IDX_W       = 3;
  localparam int OP_W        = 2;

  // Reciprocal of ten for 16-bit operands: (v * 52429) >> 19 equals v / 10.
  localparam int           RECIP_SHIFT = 19;
  localparam logic [16:0]  RECIP_TEN   = 17'd52429;

  typedef enum logic [OP_W-1:0] {
    OP_SET_NUMBER = 2'd0,
    OP_SET_DP     = 2'd1,
    OP_SCAN_TICK  = 2'd2
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_number;
    logic conv_step;
    logic dp_write;
    logic scan_load;
  } msd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;
    logic out_free;
  } msd_status_t;

  // Standard seven-segment codes, segment a in bit 0.
  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/msd_if.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver channels
// Valid/ready channels for requests into the driver and scan results out.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic                       valid;
  logic                       ready;
  logic [msd_pkg::OP_W-1:0]   op;
  logic [msd_pkg::NUM_W-1:0]  number;
  logic [msd_pkg::IDX_W-1:0]  dp_index;
  logic                       dp_on;

  modport source (output valid, op, number, dp_index, dp_on, input ready);
  modport sink   (input valid, op, number, dp_index, dp_on, output ready);
endinterface

interface msd_out_if;
  logic                       valid;
  logic                       ready;
  logic [msd_pkg::SEG_W-1:0]  segments;
  logic [msd_pkg::EN_W-1:0]   digit_enable;

  modport source (output valid, segments, digit_enable, input ready);
  modport sink   (input valid, segments, digit_enable, output ready);
endinterface

// ===== rtl/msd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver controller
// Accepts requests and sequences the digit conversion of a set-number request.
// ----------------------------------------------------------------------------
module msd_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [msd_pkg::OP_W-1:0]  in_op,
  output logic                      in_ready,
  input  msd_pkg::msd_status_t      status,
  output msd_pkg::msd_cmd_t         cmd
);
  import msd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CONV = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_SET_NUMBER: begin
              cmd.load_number = 1'b1;
              state_next      = S_CONV;
            end
            OP_SET_DP:    cmd.dp_write  = 1'b1;
            OP_SCAN_TICK: cmd.scan_load = 1'b1;
            default:      ;
          endcase
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/msd_datapath.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver datapath
// Pattern store, digit converter, scan pointer and the result register.
// ----------------------------------------------------------------------------
module msd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  msd_pkg::msd_cmd_t           cmd,
  output msd_pkg::msd_status_t        status,
  input  logic [msd_pkg::NUM_W-1:0]   in_number,
  input  logic [msd_pkg::IDX_W-1:0]   in_dp_index,
  input  logic                        in_dp_on,
  input  logic                        cfg_we,
  input  logic [msd_pkg::SEG_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msd_pkg::SEG_W-1:0]   out_segments,
  output logic [msd_pkg::EN_W-1:0]    out_digit_enable
);
  import msd_pkg::*;

  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DIGIT_COUNT - 1);

  // Segment bits a..g and the decimal point are kept apart so that a
  // decimal-point write never has to read the stored pattern.
  logic [6:0]             seg_store [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] dp_store;
  logic [SEG_W-1:0]       segment_mask;
  logic [PTR_W-1:0]       scan_ptr;
  logic [NUM_W-1:0]       value;
  logic [PTR_W-1:0]       pos;

  logic [32:0]            product;
  logic [NUM_W-1:0]       quotient;
  logic [NUM_W-1:0]       times_ten;
  logic [3:0]             remainder;
  logic                   dp_in_range;
  logic [SEG_W-1:0]       cur_pattern;
  logic [EN_W-1:0]        cur_enable;

  assign product   = {1'b0, value} * {16'd0, RECIP_TEN};
  assign quotient  = NUM_W'(product[32:RECIP_SHIFT]);
  assign times_ten = NUM_W'({quotient, 3'b000}) + NUM_W'({quotient, 1'b0});
  assign remainder = 4'(value - times_ten);

  assign status.conv_last = (quotient == '0) || (pos == '0);
  assign status.out_free  = !out_valid || out_ready;

  assign dp_in_range = {1'b0, in_dp_index} < (IDX_W + 1)'(DIGIT_COUNT);
  assign cur_pattern = {dp_store[scan_ptr], seg_store[scan_ptr]};

  always_comb begin
    for (int i = 0; i < EN_W; i++) begin
      cur_enable[i] = (i < DIGIT_COUNT) && (scan_ptr == PTR_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        seg_store[i] <= '0;
      end
      dp_store     <= '0;
      segment_mask <= '1;
      scan_ptr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        segment_mask <= cfg_wdata;
      end
      if (cmd.load_number) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          seg_store[i] <= '0;
        end
        dp_store <= '0;
      end
      if (cmd.conv_step) begin
        seg_store[pos] <= seg_code(remainder);
      end
      if (cmd.dp_write && dp_in_range) begin
        dp_store[in_dp_index[PTR_W-1:0]] <= in_dp_on;
      end
      if (cmd.scan_load) begin
        out_valid <= 1'b1;
        scan_ptr  <= (scan_ptr == LAST_POS) ? '0 : scan_ptr + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_number) begin
      value <= in_number;
      pos   <= LAST_POS;
    end else if (cmd.conv_step) begin
      value <= quotient;
      pos   <= pos - 1'b1;
    end
    if (cmd.scan_load) begin
      out_segments     <= cur_pattern & segment_mask;
      out_digit_enable <= cur_enable;
    end
  end

endmodule

// ===== rtl/multiplexed_seven_segment_driver.sv =====
// A scan-tick request shows its result in the cycle after it is accepted.
// A set-number request holds off further requests while the converter writes
// its decimal digits, one divide-by-ten step per digit and DIGIT_COUNT at
// most; decimal-point and scan-tick requests leave the controller idle.
// Reset (synchronous, active high) blanks all digits, sets the mask to all ones
// and returns the scan pointer to digit 0.
// ----------------------------------------------------------------------------
// Multiplexed seven-segment display driver
// Converts numbers to digit patterns and scans them out one digit per tick.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_driver (
  input  logic                       clk,
  input  logic                       rst,
  msd_in_if.sink                     in_ch,
  msd_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [msd_pkg::SEG_W-1:0]  cfg_wdata
);
  import msd_pkg::*;

  // The controller decides which request is taken and steps the converter;
  // the datapath holds every stored value.
  msd_cmd_t    cmd;
  msd_status_t status;

  // A new request is only taken while no conversion runs and the result
  // register is empty or being emptied in this cycle, so a scan result is
  // never overwritten before it is taken.
  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath converts the number from the right: each conversion cycle
  // divides by ten through a reciprocal multiply and writes one digit, and
  // stops when the quotient is zero or the leftmost digit is written.
  msd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_number        (in_ch.number),
    .in_dp_index      (in_ch.dp_index),
    .in_dp_on         (in_ch.dp_on),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_segments     (out_ch.segments),
    .out_digit_enable (out_ch.digit_enable)
  );

endmodule

// ===== rtl/msd_checker.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver port checker
// Watches the top-level ports for result and request sequencing errors.
// ----------------------------------------------------------------------------
module msd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [msd_pkg::OP_W-1:0]   in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [msd_pkg::SEG_W-1:0]  segments,
  input logic [msd_pkg::EN_W-1:0]   digit_enable
);
  import msd_pkg::*;

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A result that is not taken stays.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A result that is not taken holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(segments) && $stable(digit_enable))
    else $error("result changed while stalled");

  // Every result enables exactly one digit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(digit_enable))
    else $error("digit enable is not one-hot");

  // A set-number request blocks the next request while digits convert.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_op == OP_SET_NUMBER) |=> !in_ready)
    else $error("request taken during number conversion");

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .segments     (out_ch.segments),
  .digit_enable (out_ch.digit_enable)
);

// ===== sim/tb_multiplexed_seven_segment_driver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment driver testbench
// Sends set-number, decimal-point, scan-tick and unused requests with random
// gaps on both channels. A behavioral copy of the display predicts every scan
// result, which is checked field by field under several segment masks.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_driver;
  import msd_pkg::*;

  // The unused opcode is not part of op_t, so it gets a name of its own here.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Requests pushed per random phase and the quiet cycles allowed after the
  // last result before a mask write or the end. A set-number request keeps
  // the block busy without any result while its digits convert.
  localparam int PHASE_REQUESTS = 400;
  localparam int SETTLE_CYCLES  = 2 * (1 + DIGIT_COUNT);

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] number;
    logic [IDX_W-1:0] dp_index;
    logic             dp_on;
  } disp_req_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;
  } scan_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [SEG_W-1:0] cfg_wdata;

  msd_in_if  in_ch ();
  msd_out_if out_ch ();

  multiplexed_seven_segment_driver DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Requests waiting to be sent and scan results waiting to arrive.
  disp_req_t    request_q[$];
  scan_result_t scan_want_q[$];

  // Display model: one pattern per digit, the scan position and the mask.
  logic [SEG_W-1:0] digit_pat [DIGIT_COUNT];
  int               scan_pos;
  logic [SEG_W-1:0] mask_model;

  // When set, neither channel idles; used for the last part of the run.
  bit calm;

  int queued_cnt;
  int accepted_cnt;
  int result_cnt;
  int number_cnt;
  int dp_cnt;
  int ignored_cnt;
  int mask_writes;
  int errors;

  int send_gap;
  int recv_stall;

  // Standard seven-segment glyphs, segment a in bit 0, decimal point clear.
  function automatic logic [SEG_W-1:0] glyph_of(input int digit);
    logic [SEG_W-1:0] g;
    case (digit)
      0:       g = 8'h3F;
      1:       g = 8'h06;
      2:       g = 8'h5B;
      3:       g = 8'h4F;
      4:       g = 8'h66;
      5:       g = 8'h6D;
      6:       g = 8'h7D;
      7:       g = 8'h07;
      8:       g = 8'h7F;
      9:       g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Applies one accepted request to the display model. A scan tick queues
  // the pattern it should show; other requests at most change the patterns.
  task automatic update_display_model(input disp_req_t req);
    int           pos;
    int           v;
    scan_result_t res;
    if (req.op == OP_SET_NUMBER) begin
      number_cnt++;
      for (pos = 0; pos < DIGIT_COUNT; pos++) digit_pat[pos] = '0;
      v = req.number;
      if (v == 0) begin
        // A zero value still shows one '0' in the rightmost position.
        digit_pat[DIGIT_COUNT-1] = glyph_of(0);
      end else begin
        // Digits beyond the display width simply fall off the left end.
        for (pos = DIGIT_COUNT - 1; pos >= 0 && v != 0; pos--) begin
          digit_pat[pos] = glyph_of(v % 10);
          v = v / 10;
        end
      end
    end else if (req.op == OP_SET_DP) begin
      dp_cnt++;
      // An index past the last digit leaves every pattern alone.
      if (int'(req.dp_index) < DIGIT_COUNT) begin
        digit_pat[req.dp_index][7] = req.dp_on;
      end
    end else if (req.op == OP_SCAN_TICK) begin
      if (scan_pos >= DIGIT_COUNT) scan_pos = 0;
      res.segments     = digit_pat[scan_pos] & mask_model;
      res.digit_enable = '0;
      if (scan_pos < EN_W) res.digit_enable[scan_pos] = 1'b1;
      scan_want_q.push_back(res);
      scan_pos = (scan_pos + 1 >= DIGIT_COUNT) ? 0 : scan_pos + 1;
    end else begin
      ignored_cnt++;
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Request driver. A request stays on the channel until it is taken; the
  // next one follows without a gap unless an idle burst runs or none is queued.
  always @(posedge clk) begin
    disp_req_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        update_display_model('{in_ch.op, in_ch.number, in_ch.dp_index, in_ch.dp_on});
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.op       <= nxt.op;
          in_ch.number   <= nxt.number;
          in_ch.dp_index <= nxt.dp_index;
          in_ch.dp_on    <= nxt.dp_on;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure on the output channel.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (scan_want_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result segments=%02h enable=%01h",
                                    out_ch.segments, out_ch.digit_enable));
        end else begin
          want = scan_want_q.pop_front();
          if (out_ch.segments !== want.segments)
            report_mismatch($sformatf("result %0d segments got %02h want %02h",
                                      result_cnt, out_ch.segments, want.segments));
          if (out_ch.digit_enable !== want.digit_enable)
            report_mismatch($sformatf("result %0d digit_enable got %01h want %01h",
                                      result_cnt, out_ch.digit_enable,
                                      want.digit_enable));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_request(input logic [OP_W-1:0] op, input int number,
                              input int idx, input int dp);
    request_q.push_back('{op, NUM_W'(number), IDX_W'(idx), 1'(dp)});
    queued_cnt++;
  endtask

  task automatic push_scans(input int n);
    repeat (n) push_request(OP_SCAN_TICK, $urandom, $urandom, $urandom);
  endtask

  // Picks a value to display, weighted towards short numbers so that the
  // blank leading positions are exercised as often as full-width values.
  function automatic int pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return 0;
    if (r < 25) return $urandom_range(1, 9);
    if (r < 45) return $urandom_range(10, 99);
    if (r < 70) return $urandom_range(100, 9999);
    return $urandom_range(10000, 65535);
  endfunction

  // Random traffic. Most of it is a well-formed display update (a number,
  // a few decimal points, then a scan over the digits); the rest is single
  // requests of any kind, unused opcodes and out-of-range indices included.
  task automatic push_random_phase(input int count);
    int start;
    int r;
    int idx;
    start = queued_cnt;
    while (queued_cnt - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_request(OP_SET_NUMBER, pick_number(), $urandom, $urandom);
        repeat ($urandom_range(0, 3)) begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                            : $urandom_range(0, DIGIT_COUNT - 1);
          push_request(OP_SET_DP, $urandom, idx, $urandom);
        end
        push_scans($urandom_range(1, 2 * DIGIT_COUNT));
      end else if (r < 75) begin
        push_scans(1);
      end else if (r < 85) begin
        push_request(OP_SET_DP, $urandom, $urandom_range(0, 7), $urandom);
      end else if (r < 93) begin
        push_request(OP_SET_NUMBER, $urandom, $urandom, $urandom);
      end else begin
        push_request(OP_UNUSED, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Holds the caller until every queued request is taken and every scan
  // result is back, then lets a set-number still in progress finish.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || scan_want_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mask writes happen only while the block is idle, so the model takes the
  // new value right at the edge that writes it.
  task automatic write_mask(input logic [SEG_W-1:0] m);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mask_model  = m;
    mask_writes++;
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.op       = '0;
    in_ch.number   = '0;
    in_ch.dp_index = '0;
    in_ch.dp_on    = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    for (int i = 0; i < DIGIT_COUNT; i++) digit_pat[i] = '0;
    scan_pos   = 0;
    mask_model = 8'hFF;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset mask: a blank display, a zero, the
    // largest value (its top digit is dropped), decimal points in and out
    // of range, clearing a point, an unused opcode, and a set-number that
    // must wipe the points set before it.
    push_scans(1);
    push_request(OP_SET_NUMBER, 0, 0, 0);
    push_scans(DIGIT_COUNT);
    push_request(OP_SET_NUMBER, 65535, 7, 1);
    push_request(OP_SET_DP, 0, 0, 1);
    push_request(OP_SET_DP, 65535, DIGIT_COUNT - 1, 1);
    push_request(OP_SET_DP, 0, DIGIT_COUNT, 1);
    push_request(OP_SET_DP, 0, 7, 1);
    push_scans(DIGIT_COUNT);
    push_request(OP_SET_DP, 0, 0, 0);
    push_request(OP_UNUSED, 65535, 7, 1);
    push_request(OP_SET_NUMBER, 10, 0, 0);
    push_scans(DIGIT_COUNT);
    push_request(OP_SET_NUMBER, 12345, 0, 0);
    push_scans(DIGIT_COUNT);

    // Each mask write below first drains the block completely, so the
    // sender also sits still until every expected result has arrived.
    write_mask(8'h00);
    push_random_phase(PHASE_REQUESTS);
    write_mask(8'h80);
    push_random_phase(PHASE_REQUESTS);
    write_mask(8'h7F);
    push_random_phase(PHASE_REQUESTS);
    write_mask(SEG_W'($urandom));
    push_random_phase(PHASE_REQUESTS);

    // Last part: full mask and no idling on either channel.
    write_mask(8'hFF);
    calm = 1'b1;
    push_random_phase(PHASE_REQUESTS);

    wait_idle();
    $display("Covered %0d requests (%0d set-number, %0d decimal-point, %0d ignored opcode)",
             accepted_cnt, number_cnt, dp_cnt, ignored_cnt);
    $display("Checked %0d scan results across %0d segment mask settings",
             result_cnt, mask_writes + 1);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d requests pending and %0d results outstanding",
             queued_cnt - accepted_cnt, scan_want_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
